/* src/rgbfe_pkg.sv */
package rgbfe_pkg;

	// fixed field widths
	localparam int IDX_W = 6;
	localparam int LVL_W = 8;
	localparam int CNT_W = 7;

	localparam int DEF_MAX_FIXTURES = 64;
	localparam logic [CNT_W-1:0] ACTIVE_RST = 7'd64;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// input word
	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] fixture_index;
		logic [LVL_W-1:0] red_target;
		logic [LVL_W-1:0] green_target;
		logic [LVL_W-1:0] blue_target;
		logic [LVL_W-1:0] fade_rate;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [LVL_W-1:0] out_red;
		logic [LVL_W-1:0] out_green;
		logic [LVL_W-1:0] out_blue;
		logic             last;
	} out_word_t;

	// state of one fixture, held in one cell of the ring
	typedef struct packed {
		logic [LVL_W-1:0] cur_r;
		logic [LVL_W-1:0] cur_g;
		logic [LVL_W-1:0] cur_b;
		logic [LVL_W-1:0] tgt_r;
		logic [LVL_W-1:0] tgt_g;
		logic [LVL_W-1:0] tgt_b;
		logic [LVL_W-1:0] rate;
	} fixture_t;

endpackage

/* src/rgb_fixture_fade_engine.sv */
// RGB fixture fade engine. Fixture state lives in a ring of MAX_FIXTURES cells,
// cell k holding fixture k whenever the block is idle. A write word (cmd 0)
// loads one fixture's targets and rate. A tick word (cmd 1) rotates the ring
// once around, one cell per cycle unless an active fixture waits on a result
// word held by out_stall: the fixture leaving cell 0 passes through the slew
// logic (if its index is below active_fixtures, saturated to MAX_FIXTURES)
// and re-enters at the far end. After a tick word is taken, in_stall stays
// high until the whole ring has rotated; the next word can be taken once it
// falls. Each active fixture gives one result word in index order, the final
// one with last set. active_fixtures resets to 64 and is written through
// cfg_we/cfg_data; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module rgb_fixture_fade_engine #(
	parameter int MAX_FIXTURES = rgbfe_pkg::DEF_MAX_FIXTURES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rgbfe_pkg::in_word_t           in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rgbfe_pkg::out_word_t          out_word,
	input  logic                          cfg_we,
	input  logic [rgbfe_pkg::CNT_W-1:0]   cfg_data
);

	localparam int KW = (MAX_FIXTURES > 1) ? $clog2(MAX_FIXTURES) : 1;
	localparam logic [rgbfe_pkg::CNT_W-1:0] MAX_CNT = rgbfe_pkg::CNT_W'(MAX_FIXTURES);
	localparam logic [KW-1:0] LAST_K = KW'(MAX_FIXTURES - 1);

	logic [rgbfe_pkg::CNT_W-1:0] active_q;
	logic [rgbfe_pkg::CNT_W-1:0] count;
	logic                        busy_q;
	logic [KW-1:0]               k_q;
	logic [rgbfe_pkg::CNT_W-1:0] k_ext;
	logic                        in_acc;
	logic                        wr_en;
	logic                        k_active;
	logic                        advance;
	logic                        emit;
	logic                        out_valid_q;
	rgbfe_pkg::out_word_t        out_word_q;

	rgbfe_pkg::fixture_t         ring [MAX_FIXTURES];
	rgbfe_pkg::fixture_t         head;
	rgbfe_pkg::fixture_t         head_next;
	logic [rgbfe_pkg::LVL_W-1:0] new_r;
	logic [rgbfe_pkg::LVL_W-1:0] new_g;
	logic [rgbfe_pkg::LVL_W-1:0] new_b;

	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !busy_q;
	assign wr_en     = in_acc && (in_word.cmd == rgbfe_pkg::CMD_WRITE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= rgbfe_pkg::ACTIVE_RST;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	assign count    = (active_q > MAX_CNT) ? MAX_CNT : active_q;
	assign k_ext    = rgbfe_pkg::CNT_W'(k_q);
	assign k_active = k_ext < count;
	// step when the head fixture needs no output slot or the slot frees up
	assign advance  = busy_q && (!k_active || !out_valid_q || !out_stall);
	assign emit     = advance && k_active;

	// tick sequencer: one ring step per cycle, unless a held result word stalls it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (in_acc && (in_word.cmd == rgbfe_pkg::CMD_TICK)) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (advance) begin
			if (k_q == LAST_K) begin
				busy_q <= 1'b0;
				k_q    <= '0;
			end else begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	// slew on the fixture leaving the head of the ring
	assign head = ring[0];

	rgbfe_slew u_slew_r (.level(head.cur_r), .goal(head.tgt_r), .step(head.rate),
		.result(new_r));
	rgbfe_slew u_slew_g (.level(head.cur_g), .goal(head.tgt_g), .step(head.rate),
		.result(new_g));
	rgbfe_slew u_slew_b (.level(head.cur_b), .goal(head.tgt_b), .step(head.rate),
		.result(new_b));

	always_comb begin
		head_next = head;
		if (k_active) begin
			head_next.cur_r = new_r;
			head_next.cur_g = new_g;
			head_next.cur_b = new_b;
		end
	end

	// ring of fixture cells
	for (genvar i = 0; i < MAX_FIXTURES; i++) begin : g_cell
		rgbfe_pkg::fixture_t feed;
		if (i == MAX_FIXTURES - 1) begin : g_tail
			assign feed = head_next;
		end else begin : g_mid
			assign feed = ring[i+1];
		end
		rgbfe_cell #(.CELL_IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (advance),
			.shift_in (feed),
			.wr_en    (wr_en),
			.wr_index (in_word.fixture_index),
			.wr_red   (in_word.red_target),
			.wr_green (in_word.green_target),
			.wr_blue  (in_word.blue_target),
			.wr_rate  (in_word.fade_rate),
			.state    (ring[i])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q.out_index <= rgbfe_pkg::IDX_W'(k_q);
			out_word_q.out_red   <= new_r;
			out_word_q.out_green <= new_g;
			out_word_q.out_blue  <= new_b;
			out_word_q.last      <= (k_ext + rgbfe_pkg::CNT_W'(1)) == count;
		end
	end

endmodule

/* src/rgbfe_slew.sv */
module rgbfe_slew (
	input  logic [rgbfe_pkg::LVL_W-1:0] level,
	input  logic [rgbfe_pkg::LVL_W-1:0] goal,
	input  logic [rgbfe_pkg::LVL_W-1:0] step,
	output logic [rgbfe_pkg::LVL_W-1:0] result
);

	logic [rgbfe_pkg::LVL_W-1:0] up_dist;
	logic [rgbfe_pkg::LVL_W-1:0] dn_dist;

	assign up_dist = goal - level;
	assign dn_dist = level - goal;

	// move toward goal by at most step, land on goal when close enough
	always_comb begin
		if (goal > level) begin
			result = (up_dist > step) ? level + step : goal;
		end else begin
			result = (dn_dist > step) ? level - step : goal;
		end
	end

endmodule

/* src/rgbfe_cell.sv */
module rgbfe_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  rgbfe_pkg::fixture_t           shift_in,
	input  logic                          wr_en,
	input  logic [rgbfe_pkg::IDX_W-1:0]   wr_index,
	input  logic [rgbfe_pkg::LVL_W-1:0]   wr_red,
	input  logic [rgbfe_pkg::LVL_W-1:0]   wr_green,
	input  logic [rgbfe_pkg::LVL_W-1:0]   wr_blue,
	input  logic [rgbfe_pkg::LVL_W-1:0]   wr_rate,
	output rgbfe_pkg::fixture_t           state
);

	rgbfe_pkg::fixture_t fix_q;
	logic                hit;

	assign hit   = wr_en && (wr_index == rgbfe_pkg::IDX_W'(CELL_IDX));
	assign state = fix_q;

	// shift along the ring during a tick, load targets on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_q <= '0;
		end else if (shift_en) begin
			fix_q <= shift_in;
		end else if (hit) begin
			fix_q.tgt_r <= wr_red;
			fix_q.tgt_g <= wr_green;
			fix_q.tgt_b <= wr_blue;
			fix_q.rate  <= wr_rate;
		end
	end

endmodule
